/* sv/okl_pkg.sv */
// package for the ordered keyed list: field widths, command and status codes,
// controller states and the control word that is broadcast to every cell
// no dependencies
package okl_pkg;

  localparam int unsigned DEPTH_DEF = 32;
  localparam int unsigned CMD_W     = 3;
  localparam int unsigned KEY_W     = 16;
  localparam int unsigned PAY_W     = 32;
  localparam int unsigned STATUS_W  = 2;

  // stream payload widths, padded to whole bytes
  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 56;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND    = 3'd0,
    CMD_DUMP_HEAD = 3'd1,
    CMD_DUMP_TAIL = 3'd2,
    CMD_FIND      = 3'd3,
    CMD_DELETE    = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_EMPTY    = 2'd1,
    STATUS_NOTFOUND = 2'd2,
    STATUS_FULL     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DUMP
  } state_e;

  // operation that every cell performs, broadcast in the control word
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_APPEND,
    OP_ROT_HEAD,
    OP_ROT_TAIL,
    OP_DELETE
  } cell_op_e;

  typedef struct packed {
    logic [PAY_W-1:0] payload;
    logic [KEY_W-1:0] key;
  } entry_t;

  typedef struct packed {
    cell_op_e         op;
    logic             cmp_en;
    logic [KEY_W-1:0] key;
  } cell_ctrl_t;

endpackage

/* sv/okl_cell.sv */
// one slot of the list: holds an entry, compares its key against the broadcast
// key, loads the broadcast entry on append and moves entries between neighbors on rotate and delete
// depends on okl_pkg
module okl_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 6
) (
  input  logic               clk_i,
  input  okl_pkg::cell_ctrl_t ctrl_i,
  input  logic [CW-1:0]      count_i,
  input  okl_pkg::entry_t    bus_i,
  input  okl_pkg::entry_t    next_i,
  input  okl_pkg::entry_t    prev_i,
  input  logic               shift_i,
  input  logic               pick_i,
  output okl_pkg::entry_t    entry_o,
  output okl_pkg::entry_t    pick_o,
  output logic               match_o
);
  import okl_pkg::*;

  localparam logic [CW-1:0] MyIdx = CW'(IDX);

  entry_t entry_q, entry_d;
  logic   match_q, match_d;
  logic   occupied, is_tail, is_free;

  assign occupied = MyIdx < count_i;
  assign is_tail  = MyIdx == (count_i - CW'(1));
  assign is_free  = MyIdx == count_i;

  // entry movement
  always_comb begin
    entry_d = entry_q;
    unique case (ctrl_i.op)
      OP_HOLD: entry_d = entry_q;
      OP_APPEND: begin
        if (is_free) entry_d = bus_i;
      end
      OP_ROT_HEAD: begin
        if (is_tail) entry_d = bus_i;
        else if (occupied) entry_d = next_i;
      end
      OP_ROT_TAIL: begin
        if (MyIdx == '0) entry_d = bus_i;
        else if (occupied) entry_d = prev_i;
      end
      OP_DELETE: begin
        if (shift_i) entry_d = next_i;
      end
      default: entry_d = entry_q;
    endcase
  end

  // key compare, captured when a search is accepted
  always_comb begin
    match_d = match_q;
    if (ctrl_i.cmp_en) match_d = occupied && (entry_q.key == ctrl_i.key);
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    match_q <= match_d;
  end

  assign entry_o = entry_q;
  assign match_o = match_q;
  assign pick_o  = pick_i ? entry_q : '0;

endmodule

/* sv/ordered_keyed_list_top.sv */
// Ordered keyed list: a queue of up to DEPTH entries (16-bit key, 32-bit payload)
// kept in a row of cells. Commands arrive on the s_axis item channel, results
// leave on the m_axis item channel through a single output register.
// Commands: append at tail, dump from head, dump from tail, find first key from
// the head, delete first key from the head (the rest closes up in order).
// Result path by command:
//   append, and any command on an empty list: result loaded straight into the
//   output register; the next command may be accepted once that register is free
//   find and delete: compare in all cells into the match registers, then a
//   first-match pick into the output register
//   dump of N entries: rotating the cell row, one result per cycle while the output is not stalled
//   unused codes five to seven produce no result
// Dumps rotate the row one entry per result. One command is in flight at a time.
// A stalled m_axis_tready freezes the controller and the cells; no result is
// dropped. Reset empties the list; cell contents are left as they are.
// depends on okl_pkg and okl_cell
module ordered_keyed_list_top #(
  parameter int unsigned DEPTH = okl_pkg::DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // cmd[2:0], key[18:3], payload[50:19], zero fill
  input  logic [okl_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // status[1:0], entry_key[17:2], entry_payload[49:18], zero fill
  output logic [okl_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic                             m_axis_tlast
);
  import okl_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] Full = CW'(DEPTH);

  // controller state
  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] rem_q, rem_d;
  logic          del_q, del_d;
  logic          tail_q, tail_d;

  // output register
  logic             m_valid_q, m_valid_d;
  status_e          m_status_q, m_status_d;
  entry_t           m_entry_q, m_entry_d;
  logic             m_last_q, m_last_d;
  logic             out_free, out_load;

  // cell row
  cell_ctrl_t       ctrl;
  entry_t           bus;
  entry_t           cell_entry [DEPTH];
  entry_t           cell_pick  [DEPTH];
  logic [DEPTH-1:0] match_vec, prefix, first_sel, tail_sel, pick_sel;
  entry_t           picked;

  logic             accept;
  cmd_e             in_cmd;
  entry_t           in_entry;

  assign in_cmd           = cmd_e'(s_axis_tdata[CMD_W-1:0]);
  assign in_entry.key     = s_axis_tdata[CMD_W +: KEY_W];
  assign in_entry.payload = s_axis_tdata[CMD_W+KEY_W +: PAY_W];

  assign out_free      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t nxt, prv;
    if (i == DEPTH - 1) begin : g_end
      assign nxt = cell_entry[i];
    end else begin : g_mid
      assign nxt = cell_entry[i+1];
    end
    if (i == 0) begin : g_first
      assign prv = cell_entry[i];
    end else begin : g_rest
      assign prv = cell_entry[i-1];
    end
    assign tail_sel[i] = (CW'(i) == (cnt_q - CW'(1)));

    okl_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .count_i (cnt_q),
      .bus_i   (bus),
      .next_i  (nxt),
      .prev_i  (prv),
      .shift_i (prefix[i]),
      .pick_i  (pick_sel[i]),
      .entry_o (cell_entry[i]),
      .pick_o  (cell_pick[i]),
      .match_o (match_vec[i])
    );
  end

  // inclusive prefix of matches, log-depth doubling
  always_comb begin
    prefix = match_vec;
    for (int s = 0; (1 << s) < DEPTH; s++) begin
      prefix = prefix | (prefix << (1 << s));
    end
  end
  assign first_sel = prefix & ~(prefix << 1);
  assign pick_sel  = (state_q == ST_DUMP) ? tail_sel : first_sel;

  // or of the masked cell outputs
  always_comb begin
    picked = '0;
    for (int i = 0; i < DEPTH; i++) begin
      picked = picked | cell_pick[i];
    end
  end

  // controller next state and cell commands
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    rem_d      = rem_q;
    del_d      = del_q;
    tail_d     = tail_q;
    ctrl.op    = OP_HOLD;
    ctrl.cmp_en = 1'b0;
    ctrl.key   = in_entry.key;
    bus        = in_entry;
    out_load   = 1'b0;
    m_status_d = STATUS_OK;
    m_entry_d  = '0;
    m_last_d   = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_cmd) inside
            CMD_APPEND: begin
              out_load = 1'b1;
              if (cnt_q == Full) begin
                m_status_d = STATUS_FULL;
              end else begin
                ctrl.op   = OP_APPEND;
                cnt_d     = cnt_q + CW'(1);
                m_entry_d = in_entry;
              end
            end
            CMD_DUMP_HEAD, CMD_DUMP_TAIL: begin
              if (cnt_q == '0) begin
                out_load   = 1'b1;
                m_status_d = STATUS_EMPTY;
              end else begin
                state_d = ST_DUMP;
                rem_d   = cnt_q;
                tail_d  = (in_cmd == CMD_DUMP_TAIL);
              end
            end
            CMD_FIND, CMD_DELETE: begin
              if (cnt_q == '0) begin
                out_load   = 1'b1;
                m_status_d = STATUS_EMPTY;
              end else begin
                ctrl.cmp_en = 1'b1;
                del_d       = (in_cmd == CMD_DELETE);
                state_d     = ST_SEARCH;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SEARCH: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
          if (|match_vec) begin
            m_entry_d = picked;
            if (del_q) begin
              ctrl.op = OP_DELETE;
              cnt_d   = cnt_q - CW'(1);
            end
          end else begin
            m_status_d = STATUS_NOTFOUND;
          end
        end
      end
      ST_DUMP: begin
        if (out_free) begin
          out_load  = 1'b1;
          m_entry_d = tail_q ? picked : cell_entry[0];
          m_last_d  = (rem_q == CW'(1));
          ctrl.op   = tail_q ? OP_ROT_TAIL : OP_ROT_HEAD;
          bus       = tail_q ? picked : cell_entry[0];
          rem_d     = rem_q - CW'(1);
          if (rem_q == CW'(1)) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // output valid
  always_comb begin
    m_valid_d = m_valid_q;
    if (out_load) m_valid_d = 1'b1;
    else if (m_axis_tready) m_valid_d = 1'b0;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      rem_q     <= '0;
      del_q     <= 1'b0;
      tail_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      rem_q     <= rem_d;
      del_q     <= del_d;
      tail_q    <= tail_d;
      m_valid_q <= m_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_status_q <= m_status_d;
      m_entry_q  <= m_entry_d;
      m_last_q   <= m_last_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tdata  = {(OUT_DATA_W - STATUS_W - KEY_W - PAY_W)'(0),
                          m_entry_q.payload, m_entry_q.key, m_status_q};

`ifndef SYNTHESIS
  // entry count stays within the row
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= Full)
    else $error("entry count above depth");

  // a dump never runs past the entries held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DUMP |-> (rem_q != '0) && (rem_q <= cnt_q))
    else $error("dump counter out of range");

  // at most one cell is picked as first match while a search is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SEARCH |-> $onehot0(first_sel))
    else $error("several first matches");

  // a search finishes in the cycle its result is loaded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH) && out_free |=> state_q == ST_IDLE && m_axis_tvalid)
    else $error("search did not complete");
`endif

endmodule

/* dv/tb_top.sv */
// testbench for the ordered keyed list: directed command table, then random
// fill, drain and mixed runs, checked against typed rows or a queue model
// depends on okl_pkg and ordered_keyed_list_top
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import okl_pkg::*;

  localparam int unsigned LIST_DEPTH = DEPTH_DEF;
  localparam int unsigned RAND_CMDS  = 400;
  localparam int unsigned IDLE_LIMIT = 1000;
  localparam int unsigned TAIL_WAIT  = 20;

  // command codes the block ignores
  localparam logic [CMD_W-1:0] CMD_RSVD_5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD_7 = 3'd7;

  typedef struct packed {
    status_e          status;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] pay;
    logic             last;
  } result_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] pay;
    bit               typed;
    result_t          res;
  } dir_row_t;

  typedef enum int unsigned {
    MODE_FILL,
    MODE_DRAIN,
    MODE_MIXED
  } load_mode_e;

  localparam result_t NO_RES = '{STATUS_OK, 16'h0000, 32'h0000_0000, 1'b0};

  // directed commands; typed rows carry their single expected result, the
  // others take whatever the list model predicts
  localparam int unsigned DIR_N = 25;
  localparam dir_row_t DIRECTED_CMDS [DIR_N] = '{
    // every command but append on an empty list
    '{CMD_DUMP_HEAD, 16'h0000, 32'h0000_0000, 1'b1,
      '{STATUS_EMPTY, 16'h0000, 32'h0000_0000, 1'b1}},
    '{CMD_DUMP_TAIL, 16'h0000, 32'h0000_0000, 1'b1,
      '{STATUS_EMPTY, 16'h0000, 32'h0000_0000, 1'b1}},
    '{CMD_FIND, 16'h0000, 32'h0000_0000, 1'b1,
      '{STATUS_EMPTY, 16'h0000, 32'h0000_0000, 1'b1}},
    '{CMD_DELETE, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
      '{STATUS_EMPTY, 16'h0000, 32'h0000_0000, 1'b1}},
    // unused codes give nothing
    '{CMD_RSVD_5, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, NO_RES},
    '{CMD_RSVD_7, 16'h0000, 32'h0000_0000, 1'b0, NO_RES},
    // appends at the key and payload extremes, then a duplicate key
    '{CMD_APPEND, 16'h0000, 32'h0000_0000, 1'b1,
      '{STATUS_OK, 16'h0000, 32'h0000_0000, 1'b1}},
    '{CMD_APPEND, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
      '{STATUS_OK, 16'hFFFF, 32'hFFFF_FFFF, 1'b1}},
    '{CMD_APPEND, 16'h1234, 32'hA5A5_A5A5, 1'b1,
      '{STATUS_OK, 16'h1234, 32'hA5A5_A5A5, 1'b1}},
    '{CMD_APPEND, 16'h1234, 32'h5A5A_5A5A, 1'b1,
      '{STATUS_OK, 16'h1234, 32'h5A5A_5A5A, 1'b1}},
    '{CMD_APPEND, 16'h00FF, 32'h0F0F_0F0F, 1'b1,
      '{STATUS_OK, 16'h00FF, 32'h0F0F_0F0F, 1'b1}},
    '{CMD_DUMP_HEAD, 16'h0000, 32'h0000_0000, 1'b0, NO_RES},
    '{CMD_DUMP_TAIL, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, NO_RES},
    // find takes the first duplicate from the head
    '{CMD_FIND, 16'h1234, 32'h0000_0000, 1'b1,
      '{STATUS_OK, 16'h1234, 32'hA5A5_A5A5, 1'b1}},
    '{CMD_FIND, 16'h4321, 32'h0000_0000, 1'b1,
      '{STATUS_NOTFOUND, 16'h0000, 32'h0000_0000, 1'b1}},
    '{CMD_DELETE, 16'h1234, 32'h0000_0000, 1'b1,
      '{STATUS_OK, 16'h1234, 32'hA5A5_A5A5, 1'b1}},
    '{CMD_FIND, 16'h1234, 32'h0000_0000, 1'b1,
      '{STATUS_OK, 16'h1234, 32'h5A5A_5A5A, 1'b1}},
    // delete at the head, at the tail, and a miss
    '{CMD_DELETE, 16'h0000, 32'h0000_0000, 1'b1,
      '{STATUS_OK, 16'h0000, 32'h0000_0000, 1'b1}},
    '{CMD_DELETE, 16'h00FF, 32'h0000_0000, 1'b1,
      '{STATUS_OK, 16'h00FF, 32'h0F0F_0F0F, 1'b1}},
    '{CMD_DELETE, 16'h4321, 32'h0000_0000, 1'b1,
      '{STATUS_NOTFOUND, 16'h0000, 32'h0000_0000, 1'b1}},
    '{CMD_DUMP_HEAD, 16'h0000, 32'h0000_0000, 1'b0, NO_RES},
    '{CMD_RSVD_6, 16'h1234, 32'h1234_5678, 1'b0, NO_RES},
    // empty the list again
    '{CMD_DELETE, 16'hFFFF, 32'h0000_0000, 1'b1,
      '{STATUS_OK, 16'hFFFF, 32'hFFFF_FFFF, 1'b1}},
    '{CMD_DELETE, 16'h1234, 32'h0000_0000, 1'b1,
      '{STATUS_OK, 16'h1234, 32'h5A5A_5A5A, 1'b1}},
    '{CMD_DUMP_TAIL, 16'h0000, 32'h0000_0000, 1'b1,
      '{STATUS_EMPTY, 16'h0000, 32'h0000_0000, 1'b1}}
  };

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;

  // list model and the results still owed by the block
  logic [KEY_W-1:0] model_keys[$];
  logic [PAY_W-1:0] model_pays[$];
  result_t          step_res[$];
  result_t          owed_q[$];

  bit          calm = 1'b0;
  int unsigned err_count   = 0;
  int unsigned res_checked = 0;
  int unsigned cmds_sent   = 0;
  int unsigned n_full      = 0;
  int unsigned n_empty     = 0;
  int unsigned n_miss      = 0;
  int unsigned peak_fill   = 0;
  int unsigned sink_hold   = 0;

  ordered_keyed_list_top #(
    .DEPTH(LIST_DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #4 clk_i = ~clk_i;

  // wait cycles before an item on either side; none during calm runs
  function automatic int unsigned gap_draw();
    return calm ? 0 : $urandom_range(0, 9);
  endfunction

  // apply one command to the list model, leaving its results in step_res
  function automatic void list_apply(input logic [CMD_W-1:0] cmd,
                                     input logic [KEY_W-1:0] key,
                                     input logic [PAY_W-1:0] pay);
    int pos = -1;
    int n;
    step_res.delete();
    n = model_keys.size();
    if (cmd > CMD_DELETE) return;
    if (cmd == CMD_APPEND) begin
      if (n >= LIST_DEPTH) begin
        n_full++;
        step_res.push_back('{STATUS_FULL, 16'h0000, 32'h0000_0000, 1'b1});
      end else begin
        model_keys.push_back(key);
        model_pays.push_back(pay);
        if (n + 1 > peak_fill) peak_fill = n + 1;
        step_res.push_back('{STATUS_OK, key, pay, 1'b1});
      end
      return;
    end
    if (n == 0) begin
      n_empty++;
      step_res.push_back('{STATUS_EMPTY, 16'h0000, 32'h0000_0000, 1'b1});
      return;
    end
    // dumps walk the whole list in the chosen direction
    if (cmd == CMD_DUMP_HEAD || cmd == CMD_DUMP_TAIL) begin
      for (int i = 0; i < n; i++) begin
        int s;
        s = (cmd == CMD_DUMP_HEAD) ? i : n - 1 - i;
        step_res.push_back('{STATUS_OK, model_keys[s], model_pays[s], i == n - 1});
      end
      return;
    end
    // find and delete use the first match from the head
    for (int i = 0; i < n; i++) begin
      if (model_keys[i] == key) begin
        pos = i;
        break;
      end
    end
    if (pos < 0) begin
      n_miss++;
      step_res.push_back('{STATUS_NOTFOUND, 16'h0000, 32'h0000_0000, 1'b1});
      return;
    end
    step_res.push_back('{STATUS_OK, model_keys[pos], model_pays[pos], 1'b1});
    if (cmd == CMD_DELETE) begin
      model_keys.delete(pos);
      model_pays.delete(pos);
    end
  endfunction

  // key choice: mostly a small pool or a key already held, sometimes any key
  function automatic logic [KEY_W-1:0] pick_key(input bit from_list);
    int unsigned r = $urandom_range(0, 9);
    if (from_list && model_keys.size() != 0 && r < 5)
      return model_keys[$urandom_range(0, model_keys.size() - 1)];
    if (r < 8) return KEY_W'($urandom_range(0, 7));
    return KEY_W'($urandom);
  endfunction

  // present one command item and log what it should produce once accepted
  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                          input logic [PAY_W-1:0] pay, input bit typed,
                          input result_t typed_res);
    int unsigned gap;
    gap = gap_draw();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, pay, key, cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    list_apply(cmd, key, pay);
    if (typed) owed_q.push_back(typed_res);
    else foreach (step_res[i]) owed_q.push_back(step_res[i]);
  endtask

  function automatic void check_result(input result_t got);
    result_t want;
    res_checked++;
    if (owed_q.size() == 0) begin
      err_count++;
      $display("%0t: unexpected result status %0d key %h payload %h last %0d",
               $realtime, got.status, got.key, got.pay, got.last);
      return;
    end
    want = owed_q.pop_front();
    if (got.status !== want.status) begin
      err_count++;
      $display("%0t: status expected %0d actual %0d", $realtime, want.status, got.status);
    end
    if (got.key !== want.key) begin
      err_count++;
      $display("%0t: entry key expected %h actual %h", $realtime, want.key, got.key);
    end
    if (got.pay !== want.pay) begin
      err_count++;
      $display("%0t: entry payload expected %h actual %h", $realtime, want.pay, got.pay);
    end
    if (got.last !== want.last) begin
      err_count++;
      $display("%0t: last expected %0d actual %0d", $realtime, want.last, got.last);
    end
  endfunction

  // result side: check each accepted item, then stall a random number of cycles
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_result('{status_e'(m_axis_tdata[1:0]), m_axis_tdata[17:2],
                       m_axis_tdata[49:18], m_axis_tlast});
        sink_hold = gap_draw();
        if (sink_hold != 0) begin
          m_axis_tready <= 1'b0;
          sink_hold--;
        end
      end else if (!m_axis_tready) begin
        if (sink_hold == 0) m_axis_tready <= 1'b1;
        else sink_hold--;
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("%0t: no item moved for %0d cycles", $realtime, IDLE_LIMIT);
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin : stimulus
    load_mode_e       mode;
    int unsigned      run_left;
    int unsigned      r;
    logic [CMD_W-1:0] cmd;
    run_left = 0;
    mode     = MODE_MIXED;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED_CMDS[i])
      send_cmd(DIRECTED_CMDS[i].cmd, DIRECTED_CMDS[i].key, DIRECTED_CMDS[i].pay,
               DIRECTED_CMDS[i].typed, DIRECTED_CMDS[i].res);

    // random runs; long append runs push the list to full, delete runs drain it
    while (cmds_sent < RAND_CMDS) begin
      if (run_left == 0) begin
        mode     = load_mode_e'($urandom_range(0, 2));
        run_left = (mode == MODE_FILL) ? $urandom_range(40, 60) : $urandom_range(10, 40);
        calm     = ($urandom_range(0, 3) == 0);
      end
      run_left--;
      r = $urandom_range(0, 99);
      if (r < 3) begin
        cmd = CMD_RSVD_5 + CMD_W'($urandom_range(0, 2));
      end else begin
        case (mode)
          MODE_FILL: begin
            if (r < 85)      cmd = CMD_APPEND;
            else if (r < 91) cmd = CMD_FIND;
            else if (r < 94) cmd = CMD_DUMP_HEAD;
            else if (r < 97) cmd = CMD_DUMP_TAIL;
            else             cmd = CMD_DELETE;
          end
          MODE_DRAIN: begin
            if (r < 75)      cmd = CMD_DELETE;
            else if (r < 85) cmd = CMD_FIND;
            else if (r < 90) cmd = CMD_DUMP_HEAD;
            else if (r < 95) cmd = CMD_DUMP_TAIL;
            else             cmd = CMD_APPEND;
          end
          default: begin
            cmd = CMD_W'((r - 3) % 5);
          end
        endcase
        cmds_sent++;
      end
      send_cmd(cmd, pick_key(cmd != CMD_APPEND), PAY_W'($urandom), 1'b0, NO_RES);
    end
    s_axis_tvalid <= 1'b0;

    // let every owed result arrive, then watch for strays
    while (owed_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_WAIT) @(posedge clk_i);

    $display("run: %0d directed and %0d random commands, %0d results checked",
             DIR_N, cmds_sent, res_checked);
    $display("list peaked at %0d entries; full %0d, empty %0d, key missing %0d times",
             peak_fill, n_full, n_empty, n_miss);
    if (err_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("%0d mismatches", err_count);
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
